>>> design/sgs_pkg.sv
// ----------------------------------------------------------------------------
// sgs_pkg: shared types and constants of the Sobel gradient sector block
// Widths, line store depth and the record passed from front end to back end.
// ----------------------------------------------------------------------------
package sgs_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 12;
  localparam int CFG_W     = 12;
  localparam int PIX_W     = 8;
  localparam int GRAD_W    = 11;
  localparam int MAG_W     = 11;
  localparam int DIR_W     = 4;
  localparam int Q_DEPTH   = 2;

  // Register indexes on the configuration port.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Direction sector codes; the last one marks an undefined direction.
  localparam logic [DIR_W-1:0] SEC0 = 4'd0, SEC1 = 4'd1, SEC2 = 4'd2, SEC3 = 4'd3,
                               SEC4 = 4'd4, SEC5 = 4'd5, SEC6 = 4'd6, SEC7 = 4'd7;
  localparam logic [DIR_W-1:0] SEC_UNDEF = 4'd8;

  // Gradient record handed from the front end to the back end.
  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     clr_max;
    logic                     last;
  } grad_rec_t;

endpackage

>>> design/sgs_if.sv
// ----------------------------------------------------------------------------
// sgs_if: stream channels of the Sobel gradient sector block
// Pixel input channel and gradient result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sgs_in_if import sgs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;
  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface sgs_out_if import sgs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic [MAG_W-1:0]         magnitude;
  logic [DIR_W-1:0]         direction;
  logic [MAG_W-1:0]         frame_max;
  logic                     frame_last;
  modport source (output valid, grad_x, grad_y, magnitude, direction, frame_max,
                  frame_last, input ready);
  modport sink   (input valid, grad_x, grad_y, magnitude, direction, frame_max,
                  frame_last, output ready);
endinterface

>>> design/sgs_front.sv
// ----------------------------------------------------------------------------
// sgs_front: pixel intake, line stores, 3x3 window and Sobel sums
// Accepts one pixel, reads the line stores, shifts the window and pushes a
// gradient record for every interior pixel.
// ----------------------------------------------------------------------------
module sgs_front import sgs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  sgs_in_if.sink            in_ch,
  input  logic [CFG_W-1:0]  width_eff,
  input  logic [CFG_W-1:0]  height_eff,
  input  logic              q_full,
  output logic              q_push,
  output grad_rec_t         q_data
);

  typedef enum logic {F_IDLE, F_CALC} fstate_t;

  fstate_t          state_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             clr_pend_r;
  logic [PIX_W-1:0] px_r;
  logic [PIX_W-1:0] top_r, mid_r;
  logic [PIX_W-1:0] win_r [9];
  logic [PIX_W-1:0] win_nxt [9];

  logic [PIX_W-1:0] mem_top [MAX_WIDTH];
  logic [PIX_W-1:0] mem_mid [MAX_WIDTH];

  logic             accept;
  logic [COL_W-1:0] rd_addr;
  logic             row_end, frame_end, interior;
  logic signed [GRAD_W-1:0] gx, gy;

  assign in_ch.ready = (state_r == F_IDLE) && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign rd_addr     = in_ch.frame_start ? '0 : col_r;

  // Line stores: read on transfer, written back in the following cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      top_r <= mem_top[rd_addr];
      mid_r <= mem_mid[rd_addr];
    end
    if (state_r == F_CALC) begin
      mem_top[col_r] <= mid_r;
      mem_mid[col_r] <= px_r;
    end
  end

  // Window shifts left by one column, new column enters on the right.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = top_r;
    win_nxt[5] = mid_r;
    win_nxt[8] = px_r;
  end

  // Sobel sums over the updated window.
  always_comb begin
    gx = GRAD_W'(({3'b0, win_nxt[2]} + {2'b0, win_nxt[5], 1'b0} + {3'b0, win_nxt[8]})
               - ({3'b0, win_nxt[0]} + {2'b0, win_nxt[3], 1'b0} + {3'b0, win_nxt[6]}));
    gy = GRAD_W'(({3'b0, win_nxt[6]} + {2'b0, win_nxt[7], 1'b0} + {3'b0, win_nxt[8]})
               - ({3'b0, win_nxt[0]} + {2'b0, win_nxt[1], 1'b0} + {3'b0, win_nxt[2]}));
  end

  assign row_end   = ({1'b0, col_r} + (COL_W+1)'(1)) >= (COL_W+1)'(width_eff);
  assign frame_end = row_end && (({1'b0, row_r} + 13'd1) >= {1'b0, height_eff});
  assign interior  = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));

  assign q_push       = (state_r == F_CALC) && interior;
  assign q_data.gx    = gx;
  assign q_data.gy    = gy;
  assign q_data.clr_max = clr_pend_r;
  assign q_data.last  = frame_end;

  // Control and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      col_r      <= '0;
      row_r      <= '0;
      clr_pend_r <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            px_r    <= in_ch.pixel;
            state_r <= F_CALC;
            if (in_ch.frame_start) begin
              col_r      <= '0;
              row_r      <= '0;
              clr_pend_r <= 1'b1;
            end
          end
        end
        F_CALC: begin
          win_r <= win_nxt;
          if (q_push) clr_pend_r <= 1'b0;
          if (frame_end) begin
            col_r <= '0;
            row_r <= '0;
          end else if (row_end) begin
            col_r <= '0;
            row_r <= row_r + ROW_W'(1);
          end else begin
            col_r <= col_r + COL_W'(1);
          end
          state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

>>> design/sgs_fifo.sv
// ----------------------------------------------------------------------------
// sgs_fifo: short queue of gradient records
// Decouples the pixel front end from the magnitude and sector back end.
// ----------------------------------------------------------------------------
module sgs_fifo import sgs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  grad_rec_t wdata,
  input  logic      pop,
  output grad_rec_t rdata,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = $clog2(Q_DEPTH);

  grad_rec_t          mem_r [Q_DEPTH];
  logic [PTR_W-1:0]   wp_r, rp_r;
  logic [PTR_W:0]     cnt_r;

  assign full  = cnt_r == (PTR_W+1)'(Q_DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PTR_W'(Q_DEPTH-1)) ? '0 : wp_r + PTR_W'(1);
      if (pop)  rp_r <= (rp_r == PTR_W'(Q_DEPTH-1)) ? '0 : rp_r + PTR_W'(1);
      cnt_r <= cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

>>> design/sgs_back.sv
// ----------------------------------------------------------------------------
// sgs_back: magnitude, direction sector and frame maximum
// Squares the gradients, runs an iterative square root, classifies the
// direction and drives the registered result channel.
// ----------------------------------------------------------------------------
module sgs_back import sgs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  grad_rec_t q_data,
  output logic      q_pop,
  sgs_out_if.source out_ch
);

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_SQRT, B_DONE} bstate_t;

  localparam int SQ_W  = 21;
  localparam int PRD_W = 24;

  bstate_t          state_r;
  grad_rec_t        rec_r;
  logic [DIR_W-1:0] dir_r;
  logic [SQ_W-1:0]  v_r;
  logic [SQ_W:0]    res_r;
  logic [SQ_W-1:0]  bit_r;
  logic [MAG_W-1:0] max_r;

  logic signed [PRD_W-1:0] lhs, r_p2414, r_m2414, r_p414, r_m414;
  logic lt_p2414, lt_m2414, lt_p414, lt_m414, gt_p2414, gt_m414;
  logic p, n, up, dn;
  logic [DIR_W-1:0] dir_c;
  logic [SQ_W:0]    trial;
  logic [MAG_W-1:0] mag, base, new_max;
  logic             out_free;

  assign out_free = !out_ch.valid || out_ch.ready;
  assign q_pop    = (state_r == B_IDLE) && !q_empty;

  // Ratio tests gy/gx against the sector limits, scaled by 1000.
  always_comb begin
    lhs     = PRD_W'(rec_r.gy) * PRD_W'(1000);
    r_p2414 = PRD_W'(rec_r.gx) * PRD_W'(2414);
    r_m2414 = PRD_W'(rec_r.gx) * -PRD_W'(2414);
    r_p414  = PRD_W'(rec_r.gx) * PRD_W'(414);
    r_m414  = PRD_W'(rec_r.gx) * -PRD_W'(414);
    p  = !rec_r.gx[GRAD_W-1];
    n  = !p;
    up = !rec_r.gy[GRAD_W-1] && (rec_r.gy != '0);
    dn = rec_r.gy[GRAD_W-1];
    lt_p2414 = p ? (lhs < r_p2414) : (lhs > r_p2414);
    lt_m2414 = p ? (lhs < r_m2414) : (lhs > r_m2414);
    lt_p414  = p ? (lhs < r_p414)  : (lhs > r_p414);
    lt_m414  = p ? (lhs < r_m414)  : (lhs > r_m414);
    gt_p2414 = p ? (lhs > r_p2414) : (lhs < r_p2414);
    gt_m414  = p ? (lhs > r_m414)  : (lhs < r_m414);
    if ((p && dn && lt_m2414) || (n && dn && gt_p2414))     dir_c = SEC0;
    else if (p && dn && lt_m414)                            dir_c = SEC1;
    else if ((p && dn && gt_m414) || (p && up && lt_p414))  dir_c = SEC2;
    else if (p && up && lt_p2414)                           dir_c = SEC3;
    else if ((p && up && gt_p2414) || (n && up && lt_m2414)) dir_c = SEC4;
    else if (n && up && lt_m414)                            dir_c = SEC5;
    else if ((n && up && gt_m414) || (n && dn && lt_p414))  dir_c = SEC6;
    else if (n && dn && lt_p2414)                           dir_c = SEC7;
    else                                                    dir_c = SEC_UNDEF;
  end

  // One square root step and the frame maximum update.
  assign trial   = res_r + {1'b0, bit_r};
  assign mag     = res_r[MAG_W-1:0];
  assign base    = rec_r.clr_max ? '0 : max_r;
  assign new_max = (mag > base) ? mag : base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      max_r        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state_r != B_DONE) out_ch.valid <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            rec_r   <= q_data;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          v_r     <= SQ_W'(32'(rec_r.gx * rec_r.gx)) + SQ_W'(32'(rec_r.gy * rec_r.gy));
          res_r   <= '0;
          bit_r   <= SQ_W'(1) << (SQ_W-1);
          dir_r   <= dir_c;
          state_r <= B_SQRT;
        end
        B_SQRT: begin
          if ({1'b0, v_r} >= trial) begin
            v_r   <= v_r - SQ_W'(trial);
            res_r <= (res_r >> 1) + {1'b0, bit_r};
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) state_r <= B_DONE;
        end
        B_DONE: begin
          if (out_free) begin
            out_ch.valid      <= 1'b1;
            out_ch.grad_x     <= rec_r.gx;
            out_ch.grad_y     <= rec_r.gy;
            out_ch.magnitude  <= mag;
            out_ch.direction  <= dir_r;
            out_ch.frame_max  <= new_max;
            out_ch.frame_last <= rec_r.last;
            max_r   <= rec_r.last ? '0 : new_max;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

>>> design/sobel_gradient_sector_top.sv
// ----------------------------------------------------------------------------
// sobel_gradient_sector_top: streaming Sobel gradient, magnitude and sector
// Top level with configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
// Usage: pixels of a frame enter in raster order on in_ch, one per transfer;
// frame_start marks the first pixel of a frame. Every interior pixel gives
// one result on out_ch with gx, gy, floored magnitude, direction sector
// (8 = undefined), running frame maximum and a flag on the last result of
// the frame. Border pixels give no result.
// Flow: the front end takes a new pixel only after the line store
// write-back of the previous one. The back end works on one record at a
// time through the pop, square, 11-step square root loop and output
// steps, and pops the next record only after its result is registered.
// A two-entry queue lets the front end keep accepting while the back end
// works and while a finished result waits on a stalled receiver.
// Registers: image_width at address 0, image_height at address 4, written
// over the cfg_ port while the block is idle. Reset clears counters, the
// window and the frame maximum; the line stores are not cleared.
// ----------------------------------------------------------------------------
module sobel_gradient_sector_top import sgs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sgs_in_if.sink      in_ch,
  sgs_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [CFG_W-1:0] width_r, height_r, width_eff, height_eff;
  logic             q_full, q_empty, q_push, q_pop;
  grad_rec_t        q_wdata, q_rdata;

  assign cfg_pready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(640);
      height_r <= CFG_W'(480);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        REG_WIDTH:  width_r  <= cfg_pwdata[CFG_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_HEIGHT) ? {20'b0, height_r} : {20'b0, width_r};

  // Saturate the geometry to the supported range.
  assign width_eff  = (width_r < CFG_W'(3)) ? CFG_W'(3) :
                      (width_r > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_r;
  assign height_eff = (height_r < CFG_W'(3)) ? CFG_W'(3) : height_r;

  sgs_front u_front (
    .clk, .rst_n, .in_ch, .width_eff, .height_eff,
    .q_full, .q_push, .q_data(q_wdata)
  );

  sgs_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .full(q_full), .empty(q_empty)
  );

  sgs_back u_back (
    .clk, .rst_n, .q_empty, .q_data(q_rdata), .q_pop, .out_ch
  );

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Sobel gradient sector block
// A short directed table of 3x3 frames (vertical edge, exact ratio boundaries)
// is followed by a frame abandoned early at the widest setting and random
// frames of many sizes. A behavioral predictor computes each expected
// result, and the results are checked as whole records in order of arrival.
// ----------------------------------------------------------------------------
module tb;
  import sgs_pkg::*;

  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [MAG_W-1:0]         mag;
    logic [DIR_W-1:0]         dir;
    logic [MAG_W-1:0]         fmax;
    logic                     last;
  } grad_res_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic             fs;
    logic             typed;
    grad_res_t        res;
  } pix_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  sgs_in_if  in_ch();
  sgs_out_if out_ch();

  sobel_gradient_sector_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // Predictor state: line stores, window, raster position, frame maximum.
  logic [PIX_W-1:0] line_mem [2*MAX_WIDTH];
  logic [PIX_W-1:0] win [9];
  int unsigned col_pos, row_pos, peak_mag;
  int unsigned width_reg = 640, height_reg = 480;

  grad_res_t expected_q[$];
  int mismatches = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  bit calm = 1'b0;

  function automatic int unsigned floor_sqrt(int unsigned v);
    int unsigned r;
    r = 0;
    for (int b = 2048; b > 0; b = b / 2)
      if ((r + b) * (r + b) <= v) r = r + b;
    return r;
  endfunction

  // Exact comparison of gy/gx against c/1000; zero gx counts as positive.
  function automatic bit slope_below(int gx, int gy, int c);
    return (gx >= 0) ? (gy * 1000 < c * gx) : (gy * 1000 > c * gx);
  endfunction

  function automatic bit slope_above(int gx, int gy, int c);
    return (gx >= 0) ? (gy * 1000 > c * gx) : (gy * 1000 < c * gx);
  endfunction

  function automatic logic [DIR_W-1:0] sector_of_grad(int gx, int gy);
    bit p, n, up, dn;
    p = gx >= 0;
    n = !p;
    up = gy > 0;
    dn = gy < 0;
    if ((p && dn && slope_below(gx, gy, -2414)) || (n && dn && slope_above(gx, gy, 2414)))
      return SEC0;
    if (p && dn && slope_below(gx, gy, -414)) return SEC1;
    if ((p && dn && slope_above(gx, gy, -414)) || (p && up && slope_below(gx, gy, 414)))
      return SEC2;
    if (p && up && slope_below(gx, gy, 2414)) return SEC3;
    if ((p && up && slope_above(gx, gy, 2414)) || (n && up && slope_below(gx, gy, -2414)))
      return SEC4;
    if (n && up && slope_below(gx, gy, -414)) return SEC5;
    if ((n && up && slope_above(gx, gy, -414)) || (n && dn && slope_below(gx, gy, 414)))
      return SEC6;
    if (n && dn && slope_below(gx, gy, 2414)) return SEC7;
    return SEC_UNDEF;
  endfunction

  // Advance the predictor by one pixel; returns 1 when a result is due.
  function automatic bit predict_gradient(logic [PIX_W-1:0] px, logic fs,
                                          output grad_res_t r);
    int unsigned w, h, c, m;
    logic [PIX_W-1:0] top, mid;
    bit row_end, frame_end, due;
    int gx, gy;
    w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < 3) ? 3 : height_reg;
    r = '0;
    due = 1'b0;
    if (fs) begin
      col_pos = 0; row_pos = 0; peak_mag = 0;
    end
    c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    top = line_mem[MAX_WIDTH + c];
    mid = line_mem[c];
    line_mem[MAX_WIDTH + c] = mid;
    line_mem[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[3*k] = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = top; win[5] = mid; win[8] = px;
    row_end = col_pos + 1 >= w;
    frame_end = row_end && (row_pos + 1 >= h);
    if (row_pos >= 2 && col_pos >= 2) begin
      gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
         - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
      gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
         - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
      m = floor_sqrt(gx * gx + gy * gy);
      if (m > peak_mag) peak_mag = m;
      r.gx = GRAD_W'(gx); r.gy = GRAD_W'(gy); r.mag = MAG_W'(m);
      r.dir = sector_of_grad(gx, gy);
      r.fmax = MAG_W'(peak_mag);
      r.last = frame_end;
      due = 1'b1;
    end
    if (frame_end) begin
      col_pos = 0; row_pos = 0; peak_mag = 0;
    end else if (row_end) begin
      col_pos = 0; row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return due;
  endfunction

  // One pixel transfer, with an optional idle burst first. The typed result,
  // when given, stands in place of the predicted one.
  task automatic send_pixel(logic [PIX_W-1:0] px, logic fs, logic typed = 1'b0,
                            grad_res_t fixed = '0);
    grad_res_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.pixel = px;
    in_ch.frame_start = fs;
    do @(posedge clk); while (!in_ch.ready);
    pixels_sent++;
    if (predict_gradient(px, fs, r)) expected_q.push_back(typed ? fixed : r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write over the configuration port, only while the block is idle.
  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_psel = 1'b1; cfg_penable = 1'b0; cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00}; cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_WIDTH) width_reg = 32'(value[CFG_W-1:0]);
    else height_reg = 32'(value[CFG_W-1:0]);
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  task automatic set_frame_size(int unsigned w, int unsigned h);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    settings_used++;
  endtask

  // Directed frames, all 3x3: vertical edge with zero gy, then exact
  // ratio -0.414 (undefined sector) and its mirror at +0.414.
  pix_row_t dir_tbl [27] = '{
    '{8'd0, 1'b1, 1'b0, '0}, '{8'd0, 1'b0, 1'b0, '0}, '{8'd255, 1'b0, 1'b0, '0},
    '{8'd0, 1'b0, 1'b0, '0}, '{8'd0, 1'b0, 1'b0, '0}, '{8'd255, 1'b0, 1'b0, '0},
    '{8'd0, 1'b0, 1'b0, '0}, '{8'd0, 1'b0, 1'b0, '0},
    '{8'd255, 1'b0, 1'b1, '{11'sd1020, 11'sd0, 11'd1020, SEC_UNDEF, 11'd1020, 1'b1}},
    '{8'd0, 1'b0, 1'b0, '0}, '{8'd207, 1'b0, 1'b0, '0}, '{8'd245, 1'b0, 1'b0, '0},
    '{8'd0, 1'b0, 1'b0, '0}, '{8'd0, 1'b0, 1'b0, '0}, '{8'd255, 1'b0, 1'b0, '0},
    '{8'd0, 1'b0, 1'b0, '0}, '{8'd0, 1'b0, 1'b0, '0},
    '{8'd245, 1'b0, 1'b1, '{11'sd1000, -11'sd414, 11'd1082, SEC_UNDEF, 11'd1082, 1'b1}},
    '{8'd245, 1'b0, 1'b0, '0}, '{8'd207, 1'b0, 1'b0, '0}, '{8'd0, 1'b0, 1'b0, '0},
    '{8'd255, 1'b0, 1'b0, '0}, '{8'd0, 1'b0, 1'b0, '0}, '{8'd0, 1'b0, 1'b0, '0},
    '{8'd245, 1'b0, 1'b0, '0}, '{8'd0, 1'b0, 1'b0, '0}, '{8'd0, 1'b0, 1'b0, '0}
  };

  // Result side: random stall bursts, then compare against the oldest expectation.
  int stall_left = 0;
  always @(negedge clk) begin
    if (calm || !rst_n) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    grad_res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.grad_x, out_ch.grad_y, out_ch.magnitude, out_ch.direction,
              out_ch.frame_max, out_ch.frame_last};
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d expected %p got %p", results_seen, want, got);
        end
      end
    end
  end

  // Main sequence.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.pixel = '0;
    in_ch.frame_start = 1'b0;
    for (int i = 0; i < 2 * MAX_WIDTH; i++) line_mem[i] = '0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    col_pos = 0; row_pos = 0; peak_mag = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    set_frame_size(3, 3);
    foreach (dir_tbl[i])
      send_pixel(dir_tbl[i].px, dir_tbl[i].fs, dir_tbl[i].typed, dir_tbl[i].res);

    // Widest setting (4095 saturates to the line store depth), abandoned
    // partway through the first line.
    set_frame_size(12'hFFF, 12'hFFF);
    for (int i = 0; i < 30; i++)
      send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);

    // Random frames over a range of settings; the last one without idling.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_frame_size(0, 0);
        1: set_frame_size(5, 4);
        2: set_frame_size(3, 9);
        3: set_frame_size(9, 3);
        4: set_frame_size($urandom_range(3, 12), $urandom_range(3, 8));
        5: set_frame_size(4, 5);
        default: set_frame_size($urandom_range(3, 8), $urandom_range(3, 6));
      endcase
      calm = (ph == 6);
      for (int i = 0; i < 70; i++) begin
        if (ph == 2 && i == 40) wait_drained();
        send_pixel(PIX_W'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 24) == 0);
      end
    end

    in_ch.valid = 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d pixels and %0d results over %0d frame size settings.",
             pixels_sent, results_seen, settings_used);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", expected_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sobel_gradient_sector_top.f
design/sgs_pkg.sv
design/sgs_if.sv
design/sgs_front.sv
design/sgs_fifo.sv
design/sgs_back.sv
design/sobel_gradient_sector_top.sv
bench/tb.sv
